// File: src/ftt_pkg.sv
// Shared constants, record layout and controller/datapath interface types for the flow table.
package ftt_pkg;

  localparam int BUCKET_BITS = 11;
  localparam int MAX_FLOWS   = 8192;
  localparam int MAX_TOP     = 64;

  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int IDX_W       = $clog2(MAX_FLOWS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TOPN_W      = 7;
  localparam int RANK_W      = 6;
  localparam int STAT_W      = 3;

  localparam logic [TOPN_W-1:0] TOPN_RESET = TOPN_W'(10);

  localparam logic [STAT_W-1:0] STAT_UPDATED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_CREATED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ROW     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

  typedef struct packed {
    logic             link_v;
    logic [IDX_W-1:0] link_idx;
    logic [63:0]      session;
    logic [63:0]      bytes;
    logic [47:0]      packets;
    logic             app_known;
    logic [15:0]      app;
    logic             resolved;
  } rec_t;

  typedef enum logic [2:0] {
    OSEL_NONE,
    OSEL_UPD_HIT,
    OSEL_UPD_NEW,
    OSEL_DROP,
    OSEL_ROW_MID,
    OSEL_ROW_LAST,
    OSEL_EMPTY
  } osel_e;

  typedef struct packed {
    logic  latch_in;
    logic  clr_wr;
    logic  head_rd;
    logic  cur_from_head;
    logic  cur_from_link;
    logic  ent_rd;
    logic  ins_wr;
    logic  upd_wr;
    logic  rep_init;
    logic  row_init;
    logic  scan_step;
    logic  row_commit;
    osel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic cur_v;
    logic hit;
    logic full;
    logic scan_done;
    logic have_best;
    logic have_held;
    logic row_lim;
    logic lim_zero;
    logic out_free;
  } sts_t;

endpackage

// File: src/ftt_dp.sv
// Flow table datapath: bucket heads, entry memory, scan compare, report rows and output register.
module ftt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ftt_pkg::TOPN_W-1:0]    cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [63:0]                   session_id_i,
  input  logic [63:0]                   byte_count_i,
  input  logic [47:0]                   packet_count_i,
  input  logic                          endpoints_known_i,
  input  logic                          app_known_i,
  input  logic [15:0]                   app_id_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [ftt_pkg::STAT_W-1:0]    status_o,
  output logic [63:0]                   flow_session_o,
  output logic [63:0]                   flow_bytes_o,
  output logic [47:0]                   flow_packets_o,
  output logic                          flow_app_known_o,
  output logic [15:0]                   flow_app_o,
  output logic [ftt_pkg::RANK_W-1:0]    rank_o,
  output logic                          last_item_o,
  input  ftt_pkg::cmd_t                 cmd_i,
  output ftt_pkg::sts_t                 sts_o
);

  ftt_pkg::rec_t                       ent_mem [ftt_pkg::MAX_FLOWS];
  logic [ftt_pkg::IDX_W:0]             head_mem [ftt_pkg::NUM_BUCKETS];

  ftt_pkg::rec_t                       rd_q, best_q, held_q, base, new_rec;
  logic [ftt_pkg::IDX_W:0]             head_q;

  logic [ftt_pkg::TOPN_W-1:0]          top_n_q, limit, r_q;
  logic [ftt_pkg::CNT_W-1:0]           count_q, scan_i_q;
  logic [ftt_pkg::BUCKET_BITS-1:0]     clr_idx_q;
  logic                                cur_v_q;
  logic [ftt_pkg::IDX_W-1:0]           cur_idx_q, pend_idx_q, best_idx_q, held_idx_q;
  logic                                pend_q, have_best_q, have_held_q, out_v_q;
  logic [ftt_pkg::RANK_W-1:0]          held_rank_q;

  logic [63:0]                         sid_q, bytes_q;
  logic [47:0]                         pk_q;
  logic                                ek_q, ak_q;
  logic [15:0]                         app_q;

  logic [ftt_pkg::STAT_W-1:0]          stat_q;
  logic [63:0]                         o_sess_q, o_bytes_q;
  logic [47:0]                         o_pk_q;
  logic                                o_ak_q, o_last_q;
  logic [15:0]                         o_app_q;
  logic [ftt_pkg::RANK_W-1:0]          o_rank_q;

  logic                                ent_we, ent_re, head_we, scan_issue, take, out_free;
  logic [ftt_pkg::IDX_W-1:0]           ent_waddr, ent_raddr;
  logic [ftt_pkg::BUCKET_BITS-1:0]     head_waddr;
  logic [ftt_pkg::IDX_W:0]             head_wdata;

  assign limit = (top_n_q > ftt_pkg::TOPN_W'(ftt_pkg::MAX_TOP)) ?
                 ftt_pkg::TOPN_W'(ftt_pkg::MAX_TOP) : top_n_q;

  assign scan_issue = cmd_i.scan_step && (scan_i_q != count_q);
  assign ent_we     = cmd_i.ins_wr || cmd_i.upd_wr;
  assign ent_waddr  = cmd_i.ins_wr ? count_q[ftt_pkg::IDX_W-1:0] : cur_idx_q;
  assign ent_re     = cmd_i.ent_rd || scan_issue;
  assign ent_raddr  = cmd_i.scan_step ? scan_i_q[ftt_pkg::IDX_W-1:0] : cur_idx_q;
  assign head_we    = cmd_i.clr_wr || cmd_i.ins_wr;
  assign head_waddr = cmd_i.clr_wr ? clr_idx_q : sid_q[ftt_pkg::BUCKET_BITS-1:0];
  assign head_wdata = cmd_i.clr_wr ? '0 : {1'b1, count_q[ftt_pkg::IDX_W-1:0]};
  assign out_free   = !out_v_q || !out_stall_i;

  always_comb begin
    base = rd_q;
    if (cmd_i.ins_wr) begin
      base          = '0;
      base.link_v   = head_q[ftt_pkg::IDX_W];
      base.link_idx = head_q[ftt_pkg::IDX_W-1:0];
      base.session  = sid_q;
    end
    new_rec         = base;
    new_rec.bytes   = bytes_q;
    new_rec.packets = pk_q;
    if (ak_q) begin
      new_rec.app_known = 1'b1;
      new_rec.app       = app_q;
    end
    if (ek_q) begin
      new_rec.resolved = 1'b1;
    end
  end

  assign take = pend_q && rd_q.resolved &&
                (!have_held_q || (rd_q.bytes < held_q.bytes) ||
                 ((rd_q.bytes == held_q.bytes) && (pend_idx_q > held_idx_q))) &&
                (!have_best_q || (rd_q.bytes > best_q.bytes));

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= new_rec;
    end
    if (ent_re) begin
      rd_q <= ent_mem[ent_raddr];
    end
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (cmd_i.head_rd) begin
      head_q <= head_mem[session_id_i[ftt_pkg::BUCKET_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_n_q     <= ftt_pkg::TOPN_RESET;
      count_q     <= '0;
      clr_idx_q   <= '0;
      cur_v_q     <= 1'b0;
      cur_idx_q   <= '0;
      scan_i_q    <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      have_best_q <= 1'b0;
      have_held_q <= 1'b0;
      r_q         <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        top_n_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_wr) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (cmd_i.ins_wr) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.cur_from_head) begin
        cur_v_q   <= head_q[ftt_pkg::IDX_W];
        cur_idx_q <= head_q[ftt_pkg::IDX_W-1:0];
      end else if (cmd_i.cur_from_link) begin
        cur_v_q   <= rd_q.link_v;
        cur_idx_q <= rd_q.link_idx;
      end
      if (cmd_i.row_init) begin
        scan_i_q    <= '0;
        pend_q      <= 1'b0;
        have_best_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        pend_q     <= scan_issue;
        pend_idx_q <= scan_i_q[ftt_pkg::IDX_W-1:0];
        if (scan_issue) begin
          scan_i_q <= scan_i_q + 1'b1;
        end
        if (take) begin
          have_best_q <= 1'b1;
        end
      end
      if (cmd_i.rep_init) begin
        have_held_q <= 1'b0;
        r_q         <= '0;
      end else if (cmd_i.row_commit) begin
        have_held_q <= 1'b1;
        r_q         <= r_q + 1'b1;
      end
      if (cmd_i.out_sel != ftt_pkg::OSEL_NONE) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in && !req_type_i) begin
      sid_q   <= session_id_i;
      bytes_q <= byte_count_i;
      pk_q    <= packet_count_i;
      ek_q    <= endpoints_known_i;
      ak_q    <= app_known_i;
      app_q   <= app_id_i;
    end
    if (cmd_i.scan_step && take) begin
      best_q     <= rd_q;
      best_idx_q <= pend_idx_q;
    end
    if (cmd_i.row_commit) begin
      held_q      <= best_q;
      held_idx_q  <= best_idx_q;
      held_rank_q <= r_q[ftt_pkg::RANK_W-1:0];
    end
    case (cmd_i.out_sel)
      ftt_pkg::OSEL_UPD_HIT, ftt_pkg::OSEL_UPD_NEW: begin
        stat_q    <= (cmd_i.out_sel == ftt_pkg::OSEL_UPD_NEW) ?
                     ftt_pkg::STAT_CREATED : ftt_pkg::STAT_UPDATED;
        o_sess_q  <= new_rec.session;
        o_bytes_q <= new_rec.bytes;
        o_pk_q    <= new_rec.packets;
        o_ak_q    <= new_rec.app_known;
        o_app_q   <= new_rec.app;
        o_rank_q  <= '0;
        o_last_q  <= 1'b1;
      end
      ftt_pkg::OSEL_DROP: begin
        stat_q    <= ftt_pkg::STAT_DROPPED;
        o_sess_q  <= sid_q;
        o_bytes_q <= '0;
        o_pk_q    <= '0;
        o_ak_q    <= 1'b0;
        o_app_q   <= '0;
        o_rank_q  <= '0;
        o_last_q  <= 1'b1;
      end
      ftt_pkg::OSEL_ROW_MID, ftt_pkg::OSEL_ROW_LAST: begin
        stat_q    <= ftt_pkg::STAT_ROW;
        o_sess_q  <= held_q.session;
        o_bytes_q <= held_q.bytes;
        o_pk_q    <= held_q.packets;
        o_ak_q    <= held_q.app_known;
        o_app_q   <= held_q.app;
        o_rank_q  <= held_rank_q;
        o_last_q  <= (cmd_i.out_sel == ftt_pkg::OSEL_ROW_LAST);
      end
      ftt_pkg::OSEL_EMPTY: begin
        stat_q    <= ftt_pkg::STAT_EMPTY;
        o_sess_q  <= '0;
        o_bytes_q <= '0;
        o_pk_q    <= '0;
        o_ak_q    <= 1'b0;
        o_app_q   <= '0;
        o_rank_q  <= '0;
        o_last_q  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.clr_done  = (clr_idx_q == '1);
  assign sts_o.cur_v     = cur_v_q;
  assign sts_o.hit       = (rd_q.session == sid_q);
  assign sts_o.full      = (count_q == ftt_pkg::CNT_W'(ftt_pkg::MAX_FLOWS));
  assign sts_o.scan_done = (scan_i_q == count_q) && !pend_q;
  assign sts_o.have_best = have_best_q;
  assign sts_o.have_held = have_held_q;
  assign sts_o.row_lim   = ((r_q + 1'b1) == limit);
  assign sts_o.lim_zero  = (limit == '0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o      = out_v_q;
  assign status_o         = stat_q;
  assign flow_session_o   = o_sess_q;
  assign flow_bytes_o     = o_bytes_q;
  assign flow_packets_o   = o_pk_q;
  assign flow_app_known_o = o_ak_q;
  assign flow_app_o       = o_app_q;
  assign rank_o           = o_rank_q;
  assign last_item_o      = o_last_q;

endmodule

// File: src/ftt_ctrl.sv
// Flow table controller: head clearing, chain walk, insert or update, and report row selection.
module ftt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  output logic          in_stall_o,
  input  ftt_pkg::sts_t sts_i,
  output ftt_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_U_HEAD,
    S_U_CHK,
    S_U_CMP,
    S_U_HIT,
    S_U_MISS,
    S_R_ROW,
    S_R_SCAN,
    S_R_PICK,
    S_R_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          if (req_type_i) begin
            cmd_o.rep_init = 1'b1;
            state_d = sts_i.lim_zero ? S_R_FIN : S_R_ROW;
          end else begin
            cmd_o.head_rd = 1'b1;
            state_d = S_U_HEAD;
          end
        end
      end
      S_U_HEAD: begin
        cmd_o.cur_from_head = 1'b1;
        state_d = S_U_CHK;
      end
      S_U_CHK: begin
        if (sts_i.cur_v) begin
          cmd_o.ent_rd = 1'b1;
          state_d = S_U_CMP;
        end else begin
          state_d = S_U_MISS;
        end
      end
      S_U_CMP: begin
        if (sts_i.hit) begin
          state_d = S_U_HIT;
        end else begin
          cmd_o.cur_from_link = 1'b1;
          state_d = S_U_CHK;
        end
      end
      S_U_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.upd_wr  = 1'b1;
          cmd_o.out_sel = ftt_pkg::OSEL_UPD_HIT;
          state_d = S_IDLE;
        end
      end
      S_U_MISS: begin
        if (sts_i.out_free) begin
          if (sts_i.full) begin
            cmd_o.out_sel = ftt_pkg::OSEL_DROP;
          end else begin
            cmd_o.ins_wr  = 1'b1;
            cmd_o.out_sel = ftt_pkg::OSEL_UPD_NEW;
          end
          state_d = S_IDLE;
        end
      end
      S_R_ROW: begin
        cmd_o.row_init = 1'b1;
        state_d = S_R_SCAN;
      end
      S_R_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_R_PICK;
        end
      end
      S_R_PICK: begin
        if (!sts_i.have_best) begin
          state_d = S_R_FIN;
        end else if (!sts_i.have_held || sts_i.out_free) begin
          if (sts_i.have_held) begin
            cmd_o.out_sel = ftt_pkg::OSEL_ROW_MID;
          end
          cmd_o.row_commit = 1'b1;
          state_d = sts_i.row_lim ? S_R_FIN : S_R_ROW;
        end
      end
      S_R_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_sel = sts_i.have_held ? ftt_pkg::OSEL_ROW_LAST : ftt_pkg::OSEL_EMPTY;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/flow_table_top_talkers.sv
// Session flow table with top-talkers report: controller and datapath.
//
//   channel | direction | handshake                 | moves
//   --------+-----------+---------------------------+------------------------------
//   cfg     | in        | cfg_we_i                  | top_n register write
//   in      | in        | in_valid_i / in_stall_o   | update or report request
//   out     | out       | out_valid_o / out_stall_i | one result row per transfer
//
// After reset the bucket heads are cleared, one per cycle, with in_stall_o high.
// An update hit walks the chain entries passed before the match;
// a miss walks every chain entry in the bucket.
// A report gives rows up to min(top_n, 64), and the single read port of the entry memory
// scans every entry once per row.
// A stalled output holds the next result in place; the next request is taken meanwhile.
module flow_table_top_talkers (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ftt_pkg::TOPN_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [63:0]                   session_id_i,
  input  logic [63:0]                   byte_count_i,
  input  logic [47:0]                   packet_count_i,
  input  logic                          endpoints_known_i,
  input  logic                          app_known_i,
  input  logic [15:0]                   app_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ftt_pkg::STAT_W-1:0]    status_o,
  output logic [63:0]                   flow_session_o,
  output logic [63:0]                   flow_bytes_o,
  output logic [47:0]                   flow_packets_o,
  output logic                          flow_app_known_o,
  output logic [15:0]                   flow_app_o,
  output logic [ftt_pkg::RANK_W-1:0]    rank_o,
  output logic                          last_item_o
);

  ftt_pkg::cmd_t cmd;
  ftt_pkg::sts_t sts;

  ftt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_type_i),
    .session_id_i      (session_id_i),
    .byte_count_i      (byte_count_i),
    .packet_count_i    (packet_count_i),
    .endpoints_known_i (endpoints_known_i),
    .app_known_i       (app_known_i),
    .app_id_i          (app_id_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .flow_session_o    (flow_session_o),
    .flow_bytes_o      (flow_bytes_o),
    .flow_packets_o    (flow_packets_o),
    .flow_app_known_o  (flow_app_known_o),
    .flow_app_o        (flow_app_o),
    .rank_o            (rank_o),
    .last_item_o       (last_item_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule
